// File: src/ugd_pkg.sv
// shared types and constants for the utf-8 glyph decoder
package ugd_pkg;

  localparam int unsigned CpW       = 21;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BaseW     = 12;
  localparam int unsigned CntW      = 3;
  localparam int unsigned FifoDepth = 2;

  localparam logic [CpW-1:0] FoldLo     = 21'h00061;
  localparam logic [CpW-1:0] FoldHi     = 21'h0007A;
  localparam logic [CpW-1:0] FoldOffset = 21'h00020;
  localparam logic [12:0]    PrivPage   = 13'hF19;
  localparam logic [7:0]     PrivLastLo = 8'hFF;

  // configuration register indexes
  typedef enum logic {
    CfgFoldCase  = 1'b0,
    CfgGlyphBase = 1'b1
  } cfg_idx_e;

  // one request's worth of results: err_cnt errors, then an optional character
  typedef struct packed {
    logic [CntW-1:0] err_cnt;
    logic            has_char;
    logic [CpW-1:0]  cp;
  } desc_t;

endpackage

// File: src/ugd_front.sv
// front end: utf-8 sequence tracking and per-byte result classification
module ugd_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [ugd_pkg::ByteW-1:0]   data_byte_i,
  input  logic                        end_of_text_i,
  output ugd_pkg::desc_t              desc_o,
  output logic                        desc_valid_o
);

  logic [1:0]               rem_q, rem_d;
  logic [1:0]               held_q, held_d;
  logic [ugd_pkg::CpW-1:0]  pv_q, pv_d;

  logic                     is_cont;
  logic [1:0]               rem_dec;
  logic [1:0]               held_inc;
  logic [ugd_pkg::CpW-1:0]  pv_shift;
  logic [ugd_pkg::CntW-1:0] pre_err;
  ugd_pkg::desc_t           desc;

  // sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      held_q <= '0;
      pv_q   <= '0;
    end else if (accept_i) begin
      rem_q  <= rem_d;
      held_q <= held_d;
      pv_q   <= pv_d;
    end
  end

  assign is_cont  = (data_byte_i[7:6] == 2'b10);
  assign rem_dec  = rem_q - 2'd1;
  assign held_inc = held_q + 2'd1;
  assign pv_shift = {pv_q[ugd_pkg::CpW-7:0], data_byte_i[5:0]};

  // classify the byte into an error count and an optional character
  always_comb begin
    desc          = '0;
    rem_d         = rem_q;
    held_d        = held_q;
    pv_d          = pv_q;
    pre_err       = '0;
    if (rem_q != 2'd0 && is_cont) begin
      if (rem_dec == 2'd0) begin
        desc.has_char = 1'b1;
        desc.cp       = pv_shift;
        rem_d         = '0;
        held_d        = '0;
        pv_d          = '0;
      end else if (end_of_text_i) begin
        desc.err_cnt = {1'b0, held_inc};
        rem_d        = '0;
        held_d       = '0;
        pv_d         = '0;
      end else begin
        rem_d  = rem_dec;
        held_d = held_inc;
        pv_d   = pv_shift;
      end
    end else begin
      // abandoned sequence flushes its held bytes first
      if (rem_q != 2'd0) begin
        pre_err = {1'b0, held_q};
      end
      rem_d        = '0;
      held_d       = '0;
      pv_d         = '0;
      desc.err_cnt = pre_err;
      if (data_byte_i[7] == 1'b0) begin
        desc.has_char = 1'b1;
        desc.cp       = {{(ugd_pkg::CpW-ugd_pkg::ByteW){1'b0}}, data_byte_i};
      end else if (data_byte_i[7:5] == 3'b110 || data_byte_i[7:4] == 4'b1110 ||
                   data_byte_i[7:3] == 5'b11110) begin
        if (end_of_text_i) begin
          desc.err_cnt = pre_err + 3'd1;
        end else begin
          held_d = 2'd1;
          if (data_byte_i[7:5] == 3'b110) begin
            rem_d = 2'd1;
            pv_d  = {16'd0, data_byte_i[4:0]};
          end else if (data_byte_i[7:4] == 4'b1110) begin
            rem_d = 2'd2;
            pv_d  = {17'd0, data_byte_i[3:0]};
          end else begin
            rem_d = 2'd3;
            pv_d  = {18'd0, data_byte_i[2:0]};
          end
        end
      end else begin
        desc.err_cnt = pre_err + 3'd1;
      end
    end
  end

  assign desc_o       = desc;
  assign desc_valid_o = accept_i && (desc.has_char || desc.err_cnt != '0);

endmodule

// File: src/ugd_queue.sv
// small request queue between front and back end
module ugd_queue #(
  parameter int unsigned Depth = ugd_pkg::FifoDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_i,
  input  ugd_pkg::desc_t wr_data_i,
  input  logic           rd_i,
  output ugd_pkg::desc_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  ugd_pkg::desc_t  mem_q [Depth];
  logic [PtrW-1:0] wp_q, wp_d;
  logic [PtrW-1:0] rp_q, rp_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_wr;
  logic            do_rd;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && !empty_o;

  // pointer and fill count
  always_comb begin
    wp_d  = wp_q;
    rp_d  = rp_q;
    cnt_d = cnt_q;
    if (do_wr) begin
      wp_d = (wp_q == PtrW'(Depth - 1)) ? '0 : wp_q + PtrW'(1);
    end
    if (do_rd) begin
      rp_d = (rp_q == PtrW'(Depth - 1)) ? '0 : rp_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wp_q] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rp_q];

endmodule

// File: src/ugd_back.sv
// back end: expands each request into results and maps glyph codes
module ugd_back (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ugd_pkg::desc_t             desc_i,
  input  logic                       desc_valid_i,
  output logic                       desc_pop_o,
  input  logic                       fold_case_i,
  input  logic [ugd_pkg::BaseW-1:0]  glyph_base_i,
  input  logic                       pop_i,
  output logic                       empty_o,
  output logic [ugd_pkg::CpW-1:0]    code_point_o,
  output logic [ugd_pkg::CpW-1:0]    glyph_code_o,
  output logic                       malformed_o,
  output logic                       last_of_run_o
);

  logic [ugd_pkg::CntW-1:0] idx_q, idx_d;
  logic                     vld_q, vld_d;
  logic [ugd_pkg::CpW-1:0]  cp_q, cp_d;
  logic [ugd_pkg::CpW-1:0]  glyph_q, glyph_d;
  logic                     mal_q, mal_d;
  logic                     last_q, last_d;

  logic                     slot_free;
  logic                     emit;
  logic [ugd_pkg::CntW-1:0] total;
  logic                     is_last;
  logic                     is_err;
  logic [ugd_pkg::CpW-1:0]  glyph;

  assign slot_free = !vld_q || pop_i;
  assign emit      = slot_free && desc_valid_i;
  assign total     = desc_i.err_cnt + {{(ugd_pkg::CntW-1){1'b0}}, desc_i.has_char};
  assign is_last   = (idx_q == total - 3'd1);
  assign is_err    = (idx_q < desc_i.err_cnt);

  // glyph mapping: private page, then optional case fold
  always_comb begin
    glyph = desc_i.cp;
    if (desc_i.cp[20:8] == ugd_pkg::PrivPage && desc_i.cp[7:0] != ugd_pkg::PrivLastLo) begin
      glyph = {{(ugd_pkg::CpW-ugd_pkg::BaseW){1'b0}}, glyph_base_i}
            + {{(ugd_pkg::CpW-8){1'b0}}, desc_i.cp[7:0]};
    end else if (fold_case_i && desc_i.cp >= ugd_pkg::FoldLo &&
                 desc_i.cp <= ugd_pkg::FoldHi) begin
      glyph = desc_i.cp - ugd_pkg::FoldOffset;
    end
  end

  // result sequencing into the output register
  always_comb begin
    idx_d   = idx_q;
    vld_d   = vld_q;
    cp_d    = cp_q;
    glyph_d = glyph_q;
    mal_d   = mal_q;
    last_d  = last_q;
    if (slot_free) begin
      vld_d = 1'b0;
    end
    if (emit) begin
      vld_d   = 1'b1;
      mal_d   = is_err;
      cp_d    = is_err ? '0 : desc_i.cp;
      glyph_d = is_err ? '0 : glyph;
      last_d  = is_last;
      idx_d   = is_last ? '0 : idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
      vld_q <= 1'b0;
    end else begin
      idx_q <= idx_d;
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cp_q    <= cp_d;
    glyph_q <= glyph_d;
    mal_q   <= mal_d;
    last_q  <= last_d;
  end

  assign desc_pop_o    = emit && is_last;
  assign empty_o       = !vld_q;
  assign code_point_o  = cp_q;
  assign glyph_code_o  = glyph_q;
  assign malformed_o   = mal_q;
  assign last_of_run_o = last_q;

endmodule

// File: src/utf8_glyph_decoder_unit.sv
// A byte's first result goes from the front end through the request queue and the output register
// to the result ports. Throughput: one byte per cycle in while full is low, one result per cycle out
// while pop is held; a byte with several results holds the result side until all are popped, and
// the 2-entry request queue then fills up. Bytes with no result use neither queue nor result side.
// Reset (rst_ni low, asynchronous) clears sequence state, queue and output valid;
// fold_case_enable resets to 1 and glyph_base to 0.
module utf8_glyph_decoder_unit #(
  parameter int unsigned FifoDepth = ugd_pkg::FifoDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push,
  output logic                       full,
  input  logic [ugd_pkg::ByteW-1:0]  data_byte_i,
  input  logic                       end_of_text_i,
  output logic                       empty,
  input  logic                       pop,
  output logic [ugd_pkg::CpW-1:0]    code_point_o,
  output logic [ugd_pkg::CpW-1:0]    glyph_code_o,
  output logic                       malformed_o,
  output logic                       last_of_run_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_idx_i,
  input  logic [ugd_pkg::BaseW-1:0]  cfg_data_i
);

  logic                      fold_q;
  logic [ugd_pkg::BaseW-1:0] base_q;
  logic                      accept;
  ugd_pkg::desc_t            fr_desc;
  logic                      fr_valid;
  ugd_pkg::desc_t            q_desc;
  logic                      q_empty;
  logic                      q_pop;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fold_q <= 1'b1;
      base_q <= '0;
    end else if (cfg_we_i) begin
      case (ugd_pkg::cfg_idx_e'(cfg_idx_i))
        ugd_pkg::CfgFoldCase:  fold_q <= cfg_data_i[0];
        ugd_pkg::CfgGlyphBase: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign accept = push && !full;

  ugd_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .data_byte_i   (data_byte_i),
    .end_of_text_i (end_of_text_i),
    .desc_o        (fr_desc),
    .desc_valid_o  (fr_valid)
  );

  ugd_queue #(
    .Depth (FifoDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (fr_valid),
    .wr_data_i (fr_desc),
    .rd_i      (q_pop),
    .rd_data_o (q_desc),
    .full_o    (full),
    .empty_o   (q_empty)
  );

  ugd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .desc_i        (q_desc),
    .desc_valid_i  (!q_empty),
    .desc_pop_o    (q_pop),
    .fold_case_i   (fold_q),
    .glyph_base_i  (base_q),
    .pop_i         (pop),
    .empty_o       (empty),
    .code_point_o  (code_point_o),
    .glyph_code_o  (glyph_code_o),
    .malformed_o   (malformed_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
